// ===== hw/rtl/m3i_pkg.sv =====
// Shared types and widths for the 3x3 matrix inverse block.
`default_nettype none
package m3i_pkg;

   localparam int ENTRY_WIDTH = 32;
   localparam int THR_WIDTH   = 31;
   localparam int COF_WIDTH   = 2 * ENTRY_WIDTH + 1;
   localparam int DET_WIDTH   = 3 * ENTRY_WIDTH + 1;
   localparam int MAG_WIDTH   = 3 * ENTRY_WIDTH;

   typedef struct packed {
      logic signed [ENTRY_WIDTH-1:0] m_r0c0;
      logic signed [ENTRY_WIDTH-1:0] m_r0c1;
      logic signed [ENTRY_WIDTH-1:0] m_r0c2;
      logic signed [ENTRY_WIDTH-1:0] m_r1c0;
      logic signed [ENTRY_WIDTH-1:0] m_r1c1;
      logic signed [ENTRY_WIDTH-1:0] m_r1c2;
      logic signed [ENTRY_WIDTH-1:0] m_r2c0;
      logic signed [ENTRY_WIDTH-1:0] m_r2c1;
      logic signed [ENTRY_WIDTH-1:0] m_r2c2;
   } req_word_type;

   typedef struct packed {
      logic signed [ENTRY_WIDTH-1:0] inv_r0c0;
      logic signed [ENTRY_WIDTH-1:0] inv_r0c1;
      logic signed [ENTRY_WIDTH-1:0] inv_r0c2;
      logic signed [ENTRY_WIDTH-1:0] inv_r1c0;
      logic signed [ENTRY_WIDTH-1:0] inv_r1c1;
      logic signed [ENTRY_WIDTH-1:0] inv_r1c2;
      logic signed [ENTRY_WIDTH-1:0] inv_r2c0;
      logic signed [ENTRY_WIDTH-1:0] inv_r2c1;
      logic signed [ENTRY_WIDTH-1:0] inv_r2c2;
      logic                          singular;
      logic                          clipped;
   } rsp_word_type;

   typedef struct packed {
      logic [8:0][COF_WIDTH-1:0] cof;
      logic [MAG_WIDTH-1:0]      det_mag;
      logic                      det_neg;
      logic                      singular;
   } task_word_type;

   typedef struct packed {
      logic start;
      logic step;
   } lane_ctl_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DONE
   } back_state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/m3i_fifo.sv =====
// Two-entry queue between the front pipeline and the divider back end.
`default_nettype none
module m3i_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire m3i_pkg::task_word_type push_word,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        head_valid,
   output m3i_pkg::task_word_type      head_word
);
   import m3i_pkg::*;

   task_word_type mem_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;

   assign full       = (cnt_ff == 2'd2);
   assign head_valid = (cnt_ff != 2'd0);
   assign head_word  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/m3i_front.sv =====
// Front pipeline: cofactors, determinant and singular classification.
`default_nettype none
module m3i_front #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire m3i_pkg::req_word_type            req_data,
   input  wire logic [m3i_pkg::THR_WIDTH-1:0]    threshold,
   input  wire logic                             queue_full,
   output logic                                  push,
   output m3i_pkg::task_word_type                push_word
);
   import m3i_pkg::*;

   localparam int E    = ENTRY_WIDTH;
   localparam int PW   = 2 * E;
   localparam int XW   = 2 * E + 1;
   localparam int CMPW = (MAG_WIDTH > THR_WIDTH + 2 * FRAC_BITS) ?
                         MAG_WIDTH : THR_WIDTH + 2 * FRAC_BITS;
   localparam logic [3:0] LA [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam logic [3:0] LB [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam logic [3:0] RA [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam logic [3:0] RB [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

   logic                         en;
   logic signed [E-1:0]          m [9];

   logic                         v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [PW-1:0]         pl_ff [9], pr_ff [9];
   logic signed [E-1:0]          a1_ff [3], a2_ff [3];
   logic signed [COF_WIDTH-1:0]  cof2_ff [9], cof3_ff [9];
   logic signed [XW-1:0]         lo_ff [3], hi_ff [3];
   task_word_type                t4_ff, t4_in;

   logic signed [DET_WIDTH-1:0]  det;
   logic [DET_WIDTH-1:0]         det_abs;
   logic [CMPW-1:0]              mag_x, thr_x;

   assign en        = !v4_ff || !queue_full;
   assign req_ready = en;
   assign push      = v4_ff && !queue_full;
   assign push_word = t4_ff;

   always_comb begin
      m[0] = req_data.m_r0c0; m[1] = req_data.m_r0c1; m[2] = req_data.m_r0c2;
      m[3] = req_data.m_r1c0; m[4] = req_data.m_r1c1; m[5] = req_data.m_r1c2;
      m[6] = req_data.m_r2c0; m[7] = req_data.m_r2c1; m[8] = req_data.m_r2c2;
   end

   always_comb begin
      det = '0;
      for (int j = 0; j < 3; j++) begin
         det = det + (DET_WIDTH'(hi_ff[j]) <<< E) + DET_WIDTH'(lo_ff[j]);
      end
      det_abs = det[DET_WIDTH-1] ? (~det + 1'b1) : det;
      mag_x   = CMPW'(det_abs[MAG_WIDTH-1:0]);
      thr_x   = CMPW'(threshold) << (2 * FRAC_BITS);
      for (int k = 0; k < 9; k++) begin
         t4_in.cof[k] = cof3_ff[k];
      end
      t4_in.det_mag  = det_abs[MAG_WIDTH-1:0];
      t4_in.det_neg  = det[DET_WIDTH-1];
      t4_in.singular = (mag_x <= thr_x);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 9; k++) begin
            pl_ff[k]   <= m[LA[k]] * m[LB[k]];
            pr_ff[k]   <= m[RA[k]] * m[RB[k]];
            cof2_ff[k] <= COF_WIDTH'(pl_ff[k]) - COF_WIDTH'(pr_ff[k]);
            cof3_ff[k] <= cof2_ff[k];
         end
         for (int j = 0; j < 3; j++) begin
            a1_ff[j] <= m[j];
            a2_ff[j] <= a1_ff[j];
            lo_ff[j] <= a2_ff[j] * $signed({1'b0, cof2_ff[3*j][E-1:0]});
            hi_ff[j] <= a2_ff[j] * $signed(cof2_ff[3*j][COF_WIDTH-1:E]);
         end
         t4_ff <= t4_in;
      end
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/m3i_div_lane.sv =====
// One restoring divider lane: cofactor over determinant, truncated and saturated.
`default_nettype none
module m3i_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire m3i_pkg::lane_ctl_type                  ctl,
   input  wire logic signed [m3i_pkg::COF_WIDTH-1:0]   cof,
   input  wire logic                                   det_neg,
   input  wire logic [m3i_pkg::MAG_WIDTH-1:0]          det_mag,
   output logic signed [m3i_pkg::ENTRY_WIDTH-1:0]      value,
   output logic                                        clip
);
   import m3i_pkg::*;

   localparam int E  = ENTRY_WIDTH;
   localparam int NB = 2 * E + 2 * FRAC_BITS;

   logic [NB-1:0]        num_ff, num_in;
   logic [MAG_WIDTH-1:0] rem_ff, rem_in;
   logic [E-1:0]         quo_ff, quo_in;
   logic                 ovf_ff, ovf_in;
   logic                 neg_ff, neg_in;

   logic [COF_WIDTH-1:0] cof_abs;
   logic [MAG_WIDTH:0]   rs, diff;
   logic                 ge;
   logic [E-1:0]         lim, mag;

   always_comb begin
      cof_abs = cof[COF_WIDTH-1] ? (~cof + 1'b1) : cof;
      rs      = {rem_ff, num_ff[NB-1]};
      diff    = rs - {1'b0, det_mag};
      ge      = (rs >= {1'b0, det_mag});
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      if (ctl.start) begin
         num_in = {cof_abs[2*E-1:0], {(2 * FRAC_BITS){1'b0}}};
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
         neg_in = cof[COF_WIDTH-1] != det_neg;
      end else if (ctl.step) begin
         num_in = {num_ff[NB-2:0], 1'b0};
         rem_in = ge ? diff[MAG_WIDTH-1:0] : rs[MAG_WIDTH-1:0];
         quo_in = {quo_ff[E-2:0], ge};
         ovf_in = ovf_ff | quo_ff[E-1];
      end
      lim   = neg_ff ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
      clip  = ovf_ff || (quo_ff > lim);
      mag   = clip ? lim : quo_ff;
      value = neg_ff ? $signed(~mag + 1'b1) : $signed(mag);
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/m3i_back.sv =====
// Back end: nine divider lanes, sequencer and output register.
`default_nettype none
module m3i_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire m3i_pkg::task_word_type head_word,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output m3i_pkg::rsp_word_type       rsp_data
);
   import m3i_pkg::*;

   localparam int E    = ENTRY_WIDTH;
   localparam int NB   = 2 * E + 2 * FRAC_BITS;
   localparam int CNTW = $clog2(NB);

   back_state_type       state_ff, state_in;
   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [MAG_WIDTH-1:0] det_mag_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;
   lane_ctl_type         ctl;
   logic                 out_free;
   logic [MAG_WIDTH-1:0] lane_det;
   logic signed [E-1:0]  val [9];
   logic [8:0]           clips;
   rsp_word_type         result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign lane_det  = (state_ff == BK_IDLE) ? head_word.det_mag : det_mag_ff;

   for (genvar k = 0; k < 9; k++) begin : g_lane
      m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock   (clock),
         .ctl     (ctl),
         .cof     ($signed(head_word.cof[k])),
         .det_neg (head_word.det_neg),
         .det_mag (lane_det),
         .value   (val[k]),
         .clip    (clips[k])
      );
   end

   always_comb begin
      result.inv_r0c0 = val[0]; result.inv_r0c1 = val[1]; result.inv_r0c2 = val[2];
      result.inv_r1c0 = val[3]; result.inv_r1c1 = val[4]; result.inv_r1c2 = val[5];
      result.inv_r2c0 = val[6]; result.inv_r2c1 = val[7]; result.inv_r2c2 = val[8];
      result.singular = 1'b0;
      result.clipped  = |clips;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ctl          = '0;
      pop          = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               if (head_word.singular) begin
                  if (out_free) begin
                     pop             = 1'b1;
                     rsp_in          = '0;
                     rsp_in.singular = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
               end else begin
                  pop       = 1'b1;
                  ctl.start = 1'b1;
                  cnt_in    = '0;
                  state_in  = BK_RUN;
               end
            end
         end
         BK_RUN: begin
            ctl.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NB - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      cnt_ff <= cnt_in;
      if (ctl.start) begin
         det_mag_ff <= head_word.det_mag;
      end
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/matrix3_inverse.sv =====
// Top level of the 3x3 matrix inverse by adjugate, signed fixed point.
// req_valid/req_ready/req_data take one matrix word of nine signed entries.
// rsp_valid/rsp_ready/rsp_data return one word per matrix: nine inverse
// entries truncated toward zero and saturated, a singular flag and a clip flag.
// csr_we/csr_wdata write the singular threshold; it resets to zero.
// A four-stage front pipeline forms cofactors and the determinant and accepts
// one matrix per cycle while the two-word queue has room.
// The back end runs nine restoring divider lanes, one quotient bit per cycle:
// a regular matrix (Q16.16 at the default FRAC_BITS) is stepped through every
// numerator bit and then waits for the output register; a singular one goes
// to it directly once it is free. Sustained throughput follows the lanes.
// Reset empties the pipeline, queue and output register.
// When the receiver stalls, the output register holds its word, the back end
// holds a finished result, the queue fills, and then req_ready drops.
`default_nettype none
module matrix3_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire m3i_pkg::req_word_type          req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output m3i_pkg::rsp_word_type               rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [m3i_pkg::THR_WIDTH-1:0]  csr_wdata
);
   import m3i_pkg::*;

   logic [THR_WIDTH-1:0] thr_ff;
   logic                 push, full, pop, head_valid;
   task_word_type        push_word, head_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .threshold  (thr_ff),
      .queue_full (full),
      .push       (push),
      .push_word  (push_word)
   );

   m3i_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (push_word),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_word  (head_word)
   );

   m3i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_word  (head_word),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
